// ===== design/rfh_pkg.sv =====
`default_nettype none

package rfh_pkg;

  localparam logic [7:0]  MULTI_MARK     = 8'h84;
  localparam logic [7:0]  SEPARATOR      = 8'h3A;
  localparam logic [31:0] MAX_FRAG_RESET = 32'd4096;

  // register index taken from paddr[2]
  localparam logic        REG_MAX_FRAG   = 1'b0;

  typedef struct packed {
    logic latch_in;     // capture input byte and length
    logic start_div;    // begin fragment count division
    logic load_rec;     // division finished: set up new record
    logic emit_hdr;     // load next header byte into output register
    logic emit_pay;     // load payload byte into output register
    logic pay_from_in;  // payload byte comes straight from the input port
  } cmd_t;

  typedef struct packed {
    logic rec_idle;     // no record in progress
    logic frag_zero;    // a new fragment starts with the next byte
    logic len_zero;     // offered record length is zero
    logic div_done;     // divider result valid this cycle
    logic hdr_last;     // the header byte up next closes the header
    logic out_free;     // output register can take a byte this cycle
  } status_t;

endpackage

`default_nettype wire

// ===== design/record_fragmenter_with_headers.sv =====
`default_nettype none

// Splits a record of bytes into fragments of at most max_fragment_bytes and
// puts a header (index ':' count ':') before each fragment; values of 128
// and up are coded as 0x84 plus four little-endian bytes. Payload bytes
// inside a fragment pass at one per cycle while the output is not stalled.
// The first byte of a record waits for the fragment count, which comes from
// a one-bit-per-cycle divider, and then for its header; every later fragment
// start waits for its header of 4 to 12 bytes. A byte arriving while idle
// with length zero is dropped. Register max_fragment_bytes sits at byte
// address 0; a value of zero acts as one. No clearing pass after reset.
module record_fragmenter_with_headers import rfh_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic [31:0] record_length_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       out_byte_o,
  output logic             is_header_o,
  output logic [31:0]      fragment_number_o,
  output logic             fragment_end_o,
  output logic             record_end_o,
  output logic             last_o
);

  logic [31:0] max_frag_q;
  logic        cfg_wr;
  logic        in_ready;
  cmd_t        cmd;
  status_t     status;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_MAX_FRAG) ? max_frag_q : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_frag_q <= MAX_FRAG_RESET;
    end else if (cfg_wr && (paddr[2] == REG_MAX_FRAG)) begin
      max_frag_q <= pwdata;
    end
  end

  rfh_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rfh_datapath u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .max_frag_i        (max_frag_q),
    .data_byte_i       (data_byte_i),
    .record_length_i   (record_length_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .out_byte_o        (out_byte_o),
    .is_header_o       (is_header_o),
    .fragment_number_o (fragment_number_o),
    .fragment_end_o    (fragment_end_o),
    .record_end_o      (record_end_o),
    .last_o            (last_o)
  );

  assign in_stall_o = !in_ready;

`ifndef NO_ASSERTIONS
  a_one_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.emit_hdr && cmd.emit_pay))
    else $error("header and payload emitted in the same cycle");

  a_no_emit_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> !(cmd.emit_hdr || cmd.emit_pay))
    else $error("output register overwritten while stalled");

  a_hdr_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && is_header_o) |-> !(last_o || fragment_end_o || record_end_o))
    else $error("header byte carries payload flags");

  a_rec_end_frag_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && record_end_o) |-> (fragment_end_o && last_o))
    else $error("record end without fragment end");

  a_div_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.start_div |=> in_stall_o)
    else $error("input accepted while fragment count pending");
`endif

endmodule

`default_nettype wire

// ===== design/rfh_div.sv =====
`default_nettype none

// Restoring unsigned divider, one quotient bit per cycle.
module rfh_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [31:0] dividend_i,
  input  wire logic [31:0] divisor_i,
  output logic             done_o,
  output logic [31:0]      quot_o,
  output logic [31:0]      rem_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [31:0] quot_q, quot_d;
  logic [31:0] rem_q, rem_d;
  logic [31:0] dvs_q, dvs_d;
  logic [32:0] shifted;
  logic [32:0] diff;

  assign shifted = {rem_q, quot_q[31]};
  assign diff    = shifted - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quot_d = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (shifted >= {1'b0, dvs_q}) begin
        rem_d  = diff[31:0];
        quot_d = {quot_q[30:0], 1'b1};
      end else begin
        rem_d  = shifted[31:0];
        quot_d = {quot_q[30:0], 1'b0};
      end
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

// ===== design/rfh_datapath.sv =====
`default_nettype none

module rfh_datapath import rfh_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire cmd_t        cmd_i,
  output status_t          status_o,
  input  wire logic [31:0] max_frag_i,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic [31:0] record_length_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       out_byte_o,
  output logic             is_header_o,
  output logic [31:0]      fragment_number_o,
  output logic             fragment_end_o,
  output logic             record_end_o,
  output logic             last_o
);

  logic [7:0]  byte_q;
  logic [31:0] len_q;
  logic [31:0] rec_q, rec_d;
  logic [31:0] frag_q, frag_d;
  logic [31:0] cur_q, cur_d;
  logic [31:0] tot_q, tot_d;
  logic [1:0]  phase_q, phase_d;
  logic [2:0]  sub_q, sub_d;
  logic        ovalid_q, ovalid_d;
  logic [7:0]  obyte_q;
  logic        ohdr_q, ofend_q, orend_q, olast_q;
  logic [31:0] ofrag_q;

  logic        div_done;
  logic [31:0] div_quot;
  logic [31:0] div_rem;
  logic [31:0] mx;
  logic [31:0] hv;
  logic        hv_short;
  logic        val_done;
  logic        hdr_first;
  logic [7:0]  hdr_byte;
  logic [7:0]  pay_byte;
  logic        fend;
  logic        rend;
  logic        out_free;

  // a maximum of zero behaves as one
  assign mx = (max_frag_i == '0) ? 32'd1 : max_frag_i;

  rfh_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.start_div),
    .dividend_i (record_length_i),
    .divisor_i  (mx),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // header: index, ':', count, ':'; values of 128 and up are mark + 4 LE bytes
  assign hv        = phase_q[1] ? tot_q : cur_q;
  assign hv_short  = (hv[31:7] == '0);
  assign val_done  = phase_q[0] || hv_short || (sub_q == 3'd4);
  assign hdr_first = (phase_q == 2'd0) && (sub_q == 3'd0);

  always_comb begin
    if (phase_q[0]) begin
      hdr_byte = SEPARATOR;
    end else if (hv_short) begin
      hdr_byte = hv[7:0];
    end else begin
      unique case (sub_q)
        3'd0:    hdr_byte = MULTI_MARK;
        3'd1:    hdr_byte = hv[7:0];
        3'd2:    hdr_byte = hv[15:8];
        3'd3:    hdr_byte = hv[23:16];
        default: hdr_byte = hv[31:24];
      endcase
    end
  end

  assign pay_byte = cmd_i.pay_from_in ? data_byte_i : byte_q;
  assign fend     = (frag_q == 32'd1);
  assign rend     = (rec_q == 32'd1);
  assign out_free = !ovalid_q || !out_stall_i;

  always_comb begin
    rec_d   = rec_q;
    frag_d  = frag_q;
    cur_d   = cur_q;
    tot_d   = tot_q;
    phase_d = phase_q;
    sub_d   = sub_q;
    if (cmd_i.load_rec) begin
      rec_d  = len_q;
      frag_d = '0;
      cur_d  = '0;
      tot_d  = div_quot + {31'd0, (div_rem != '0)};
    end
    if (cmd_i.emit_hdr) begin
      if (hdr_first) begin
        frag_d = (rec_q > mx) ? mx : rec_q;
      end
      if (val_done) begin
        sub_d   = '0;
        phase_d = phase_q + 2'd1;
      end else begin
        sub_d = sub_q + 3'd1;
      end
    end
    if (cmd_i.emit_pay) begin
      rec_d = rec_q - 32'd1;
      if (rend) begin
        frag_d = '0;
        cur_d  = '0;
        tot_d  = '0;
      end else begin
        frag_d = frag_q - 32'd1;
        if (fend) begin
          cur_d = cur_q + 32'd1;
        end
      end
    end
  end

  always_comb begin
    ovalid_d = ovalid_q;
    if (cmd_i.emit_hdr || cmd_i.emit_pay) begin
      ovalid_d = 1'b1;
    end else if (!out_stall_i) begin
      ovalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_q    <= '0;
      frag_q   <= '0;
      cur_q    <= '0;
      tot_q    <= '0;
      phase_q  <= '0;
      sub_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      rec_q    <= rec_d;
      frag_q   <= frag_d;
      cur_q    <= cur_d;
      tot_q    <= tot_d;
      phase_q  <= phase_d;
      sub_q    <= sub_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      byte_q <= data_byte_i;
      len_q  <= record_length_i;
    end
    if (cmd_i.emit_hdr) begin
      obyte_q <= hdr_byte;
      ohdr_q  <= 1'b1;
      ofrag_q <= cur_q;
      ofend_q <= 1'b0;
      orend_q <= 1'b0;
      olast_q <= 1'b0;
    end else if (cmd_i.emit_pay) begin
      obyte_q <= pay_byte;
      ohdr_q  <= 1'b0;
      ofrag_q <= cur_q;
      ofend_q <= fend;
      orend_q <= rend;
      olast_q <= 1'b1;
    end
  end

  assign status_o.rec_idle  = (rec_q == '0);
  assign status_o.frag_zero = (frag_q == '0);
  assign status_o.len_zero  = (record_length_i == '0);
  assign status_o.div_done  = div_done;
  assign status_o.hdr_last  = (phase_q == 2'd3);
  assign status_o.out_free  = out_free;

  assign out_valid_o       = ovalid_q;
  assign out_byte_o        = obyte_q;
  assign is_header_o       = ohdr_q;
  assign fragment_number_o = ofrag_q;
  assign fragment_end_o    = ofend_q;
  assign record_end_o      = orend_q;
  assign last_o            = olast_q;

endmodule

`default_nettype wire

// ===== design/rfh_ctrl.sv =====
`default_nettype none

module rfh_ctrl import rfh_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire status_t status_i,
  output cmd_t         cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_HDR  = 2'd2;
  localparam logic [1:0] S_PAY  = 2'd3;

  logic [1:0] state_q, state_d;
  logic       accept;

  assign in_ready_o = (state_q == S_IDLE) && status_i.out_free;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.latch_in = 1'b1;
          if (status_i.rec_idle) begin
            // a zero-length record start is dropped
            if (!status_i.len_zero) begin
              cmd_o.start_div = 1'b1;
              state_d         = S_DIV;
            end
          end else if (status_i.frag_zero) begin
            state_d = S_HDR;
          end else begin
            cmd_o.emit_pay    = 1'b1;
            cmd_o.pay_from_in = 1'b1;
          end
        end
      end
      S_DIV: begin
        if (status_i.div_done) begin
          cmd_o.load_rec = 1'b1;
          state_d        = S_HDR;
        end
      end
      S_HDR: begin
        if (status_i.out_free) begin
          cmd_o.emit_hdr = 1'b1;
          if (status_i.hdr_last) begin
            state_d = S_PAY;
          end
        end
      end
      default: begin
        if (status_i.out_free) begin
          cmd_o.emit_pay = 1'b1;
          state_d        = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== tb/record_fragmenter_with_headers_tb.sv =====
`timescale 1ns / 1ps

module record_fragmenter_with_headers_tb;
  import rfh_pkg::*;

  localparam logic [2:0]  ADDR_MAX_FRAG = {REG_MAX_FRAG, 2'b00};
  localparam logic [2:0]  ADDR_NO_REG   = {~REG_MAX_FRAG, 2'b00};
  localparam int unsigned SHORT_LIMIT   = 128;
  localparam int unsigned CYCLE_LIMIT   = 1_200_000;
  localparam int unsigned SETTLE_CYCLES = 80;
  localparam int unsigned MAX_REPORTS   = 50;

  typedef struct packed {
    logic [7:0]  val;
    logic        hdr;
    logic [31:0] frag;
    logic        fend;
    logic        rend;
    logic        lst;
  } frag_byte_t;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  data_byte_i;
  logic [31:0] record_length_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [7:0]  out_byte_o;
  logic        is_header_o;
  logic [31:0] fragment_number_o;
  logic        fragment_end_o;
  logic        record_end_o;
  logic        last_o;

  // predicted output bytes, oldest first
  frag_byte_t  expected_bytes[$];

  // predictor copy of the block state and register
  logic [31:0] max_frag   = MAX_FRAG_RESET;
  logic [31:0] rec_left   = '0;
  logic [31:0] frag_left  = '0;
  logic [31:0] cur_frag   = '0;
  logic [31:0] frag_count = '0;

  int          errors = 0;
  bit          quiet = 1'b0;
  int          stall_cnt = 0;
  int unsigned cycles = 0;

  record_fragmenter_with_headers uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .data_byte_i       (data_byte_i),
    .record_length_i   (record_length_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .out_byte_o        (out_byte_o),
    .is_header_o       (is_header_o),
    .fragment_number_o (fragment_number_o),
    .fragment_end_o    (fragment_end_o),
    .record_end_o      (record_end_o),
    .last_o            (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // mostly short gaps, a few long ones
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80)
      return $urandom_range(1, 3);
    else if (r < 95)
      return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk_i) begin
    if (stall_cnt == 0 && !quiet && $urandom_range(0, 99) < 20)
      stall_cnt = gap_len();
    if (stall_cnt > 0) begin
      out_stall_i <= 1'b1;
      stall_cnt--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  function automatic frag_byte_t out_rec(logic [7:0] v, logic hdr, logic fe, logic re,
                                         logic lt);
    frag_byte_t r;
    r.val  = v;
    r.hdr  = hdr;
    r.frag = cur_frag;
    r.fend = fe;
    r.rend = re;
    r.lst  = lt;
    return r;
  endfunction

  // short form below 128, else marker byte plus 4 bytes little-endian
  task automatic push_hdr_value(input logic [31:0] v);
    if (v < SHORT_LIMIT) begin
      expected_bytes.push_back(out_rec(v[7:0], 1'b1, 1'b0, 1'b0, 1'b0));
    end else begin
      expected_bytes.push_back(out_rec(MULTI_MARK, 1'b1, 1'b0, 1'b0, 1'b0));
      for (int i = 0; i < 4; i++)
        expected_bytes.push_back(out_rec(v[8*i +: 8], 1'b1, 1'b0, 1'b0, 1'b0));
    end
  endtask

  task automatic predict_fragments(input logic [7:0] b, input logic [31:0] len);
    logic [31:0] mx;
    logic        fe;
    logic        re;
    mx = (max_frag == 0) ? 32'd1 : max_frag;
    if (rec_left == 0) begin
      // zero length while idle: byte is dropped
      if (len == 0)
        return;
      rec_left   = len;
      frag_count = len / mx + ((len % mx != 0) ? 32'd1 : 32'd0);
      cur_frag   = '0;
      frag_left  = '0;
    end
    if (frag_left == 0) begin
      frag_left = (rec_left > mx) ? mx : rec_left;
      push_hdr_value(cur_frag);
      expected_bytes.push_back(out_rec(SEPARATOR, 1'b1, 1'b0, 1'b0, 1'b0));
      push_hdr_value(frag_count);
      expected_bytes.push_back(out_rec(SEPARATOR, 1'b1, 1'b0, 1'b0, 1'b0));
    end
    frag_left--;
    rec_left--;
    fe = (frag_left == 0);
    re = (rec_left == 0);
    expected_bytes.push_back(out_rec(b, 1'b0, fe, re, 1'b1));
    if (re) begin
      frag_left  = '0;
      cur_frag   = '0;
      frag_count = '0;
    end else if (fe) begin
      cur_frag++;
    end
  endtask

  always @(posedge clk_i) begin
    frag_byte_t got;
    frag_byte_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {out_byte_o, is_header_o, fragment_number_o, fragment_end_o, record_end_o,
             last_o};
      if (expected_bytes.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected output byte %h hdr %b frag %0d", $time, got.val,
                   got.hdr, got.frag);
      end else begin
        want = expected_bytes.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: expected %h %b %0d %b %b %b, got %h %b %0d %b %b %b", $time,
                     want.val, want.hdr, want.frag, want.fend, want.rend, want.lst,
                     got.val, got.hdr, got.frag, got.fend, got.rend, got.lst);
        end
      end
    end
  end

  // one input transaction; valid stays high when no gap follows
  task automatic send_byte(input logic [7:0] b, input logic [31:0] len);
    int gap;
    gap = (quiet || $urandom_range(0, 99) < 55) ? 0 : gap_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    data_byte_i     <= b;
    record_length_i <= len;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_fragments(b, len);
  endtask

  // length rides on the first byte; later bytes carry junk lengths
  task automatic send_record(input logic [31:0] len, input int unsigned count);
    send_byte(8'($urandom), len);
    repeat (count - 1) send_byte(8'($urandom), $urandom);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_bytes.size() != 0);
    // a dropped byte leaves no trace in the queue
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_max_frag();
    logic [31:0] rd;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_MAX_FRAG;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd !== max_frag) begin
      errors++;
      $display("%0t: max_fragment_bytes read expected %h got %h", $time, max_frag, rd);
    end
  endtask

  task automatic set_max_frag(input logic [31:0] v);
    wait_idle();
    apb_write(ADDR_MAX_FRAG, v);
    max_frag = v;
    check_max_frag();
  endtask

  task automatic test_reset_state();
    check_max_frag();
    send_byte(8'h5A, 32'd0);
    send_byte(8'h00, 32'd3);
    send_byte(8'hFF, $urandom);
    send_byte(SEPARATOR, $urandom);
    send_byte(MULTI_MARK, 32'd1);
  endtask

  task automatic test_config_extremes();
    // zero acts as one byte per fragment
    set_max_frag(32'd0);
    send_record(32'd3, 3);
    wait_idle();
    apb_write(ADDR_NO_REG, $urandom);
    check_max_frag();
    send_record(32'd2, 2);
    set_max_frag(32'hFFFF_FFFF);
    send_byte(8'hFF, 32'd2);
    send_byte(8'h00, $urandom);
    set_max_frag(32'd2);
    send_record(32'd5, 5);
    set_max_frag(32'd1);
    send_record(32'd4, 4);
  endtask

  task automatic test_random_records();
    int unsigned items;
    int unsigned nrec;
    int unsigned len;
    logic [31:0] mx;
    items = 0;
    while (items < 90) begin
      quiet = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: mx = $urandom_range(1, 6);
        6, 7:             mx = $urandom_range(7, 20);
        8:                mx = $urandom | 32'h8000_0000;
        default:          mx = 32'd0;
      endcase
      set_max_frag(mx);
      nrec = $urandom_range(1, 4);
      repeat (nrec) begin
        if ($urandom_range(0, 9) == 0)
          send_byte(8'($urandom), 32'd0);
        case ($urandom_range(0, 19))
          0:       len = $urandom_range(128, 136);
          1, 2, 3: len = (mx != 0 && mx <= 20) ? mx * $urandom_range(1, 3) : 1;
          default: len = $urandom_range(1, 16);
        endcase
        send_record(len, len);
        items += len;
      end
    end
    quiet = 1'b0;
  endtask

  // record never completes; pushes index and count into the long form
  task automatic test_open_record();
    set_max_frag(32'd1);
    send_record($urandom | 32'h8000_0000, 135);
  endtask

  initial begin
    rst_ni          <= 1'b0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    in_valid_i      <= 1'b0;
    data_byte_i     <= '0;
    record_length_i <= '0;
    out_stall_i     <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_state();
    test_config_extremes();
    test_random_records();
    test_open_record();
    wait_idle();

    if (errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

// ===== sim.f =====
design/rfh_pkg.sv
design/rfh_div.sv
design/rfh_datapath.sv
design/rfh_ctrl.sv
design/record_fragmenter_with_headers.sv
tb/record_fragmenter_with_headers_tb.sv
